// ----- rtl/stq_pkg.sv -----
// Shared types and codes for the sleep timer queue.
package stq_pkg;

  localparam logic ACT_SLEEP = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [2:0] POL_RR      = 3'd0;
  localparam logic [2:0] POL_ML      = 3'd1;
  localparam logic [2:0] POL_PRIO    = 3'd2;

  localparam logic CFG_POLICY     = 1'b0;
  localparam logic CFG_MAX_QUANTA = 1'b1;

  localparam logic [2:0] POLICY_RESET     = POL_RR;
  localparam logic [7:0] MAX_QUANTA_RESET = 8'd4;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic        action;
    logic [5:0]  thread_id;
    logic [31:0] delay;
    logic [31:0] now;
    logic        current_in_rr;
  } req_t;

  typedef struct packed {
    logic       wake_valid;
    logic [5:0] wake_thread;
    logic       yield_now;
    logic       leave_rr;
    logic       queue_full;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [5:0]  id;
    logic [31:0] wake;
  } entry_t;

  typedef struct packed {
    logic        carry;
    logic [31:0] sum;
  } alu_res_t;

endpackage

// ----- rtl/stq_alu.sv -----
// Shared 32-bit add/subtract unit with carry out.
module stq_alu (
  input  logic                  op,
  input  logic [31:0]           a,
  input  logic [31:0]           b,
  output stq_pkg::alu_res_t     res
);
  import stq_pkg::*;

  logic [31:0] b_eff;
  logic [32:0] sum33;

  assign b_eff = (op == ALU_SUB) ? ~b : b;
  // carry set: add overflowed, or on subtract a >= b
  assign sum33 = {1'b0, a} + {1'b0, b_eff} + 33'(op == ALU_SUB);
  assign res.carry = sum33[32];
  assign res.sum   = sum33[31:0];

endmodule

// ----- rtl/stq_table.sv -----
// Sleeper table memory: one write port, one registered read port.
module stq_table #(
  parameter int SLOTS = 16,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IW-1:0]        waddr,
  input  stq_pkg::entry_t      wdata,
  input  logic                 re,
  input  logic [IW-1:0]        raddr,
  output stq_pkg::entry_t      rdata
);
  import stq_pkg::*;

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/stq_quanta.sv -----
// Per-thread quanta counters: memory with per-entry valid bits, unwritten reads as zero.
module stq_quanta #(
  parameter int THREADS = 64,
  localparam int QW = $clog2(THREADS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          re,
  input  logic [QW-1:0] raddr,
  output logic [7:0]    rdata,
  input  logic          we,
  input  logic [QW-1:0] waddr,
  input  logic [7:0]    wdata
);
  logic [7:0]         mem [THREADS];
  logic [THREADS-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : 8'd0;
    end
  end

endmodule

// ----- rtl/sleep_timer_queue_with_preempt.sv -----
// Sleep timer queue: sequencer scanning the sleeper table through one shared adder.
// Sleep request: busy in ST_SLEEP only, no result; full table: queue_full result in the cycle after start.
// Tick: busy through the scan and the decision (one entry per cycle through the shared adder);
//   wake results stream at most one per cycle, final decision result follows the scan.
// A new request is taken once busy drops; results cannot be stalled.
// Reset empties the table, zeroes all quanta counters and restores policy and max_quanta.
module sleep_timer_queue_with_preempt #(
  parameter int SLOTS   = 16,
  parameter int THREADS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  stq_pkg::req_t     req,
  output logic              res_valid,
  output stq_pkg::res_t     res,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [7:0]        cfg_data
);
  import stq_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int QW = $clog2(THREADS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SLEEP  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;

  logic [2:0]    state;
  logic [2:0]    policy;
  logic [7:0]    max_quanta;
  req_t          itm;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_cnt;
  logic [CW-1:0] kept;
  logic          rd_pend;

  logic          accept;
  logic          full;
  logic          issue;
  logic          expired;
  logic [31:0]   wake_sat;
  logic          alu_op;
  logic [31:0]   alu_b;
  alu_res_t      alu_out;

  logic          tbl_we;
  logic [IW-1:0] tbl_waddr;
  entry_t        tbl_wdata;
  entry_t        tbl_rdata;

  logic [7:0]    q_rd;
  logic [7:0]    q_inc;
  logic          counting;
  logic          tid_ok;
  logic          q_we;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign full    = (count == CW'(SLOTS));
  assign issue   = (rd_cnt != count);

  // shared adder: now + delay on sleep, now - wake on scan
  assign alu_op = (state == ST_SLEEP) ? ALU_ADD : ALU_SUB;
  assign alu_b  = (state == ST_SLEEP) ? itm.delay : tbl_rdata.wake;

  stq_alu u_alu (
    .op  (alu_op),
    .a   (itm.now),
    .b   (alu_b),
    .res (alu_out)
  );

  assign wake_sat = alu_out.carry ? '1 : alu_out.sum;
  assign expired  = alu_out.carry;

  assign tbl_we    = (state == ST_SLEEP) || (state == ST_SCAN && rd_pend && !expired);
  assign tbl_waddr = (state == ST_SLEEP) ? count[IW-1:0] : kept[IW-1:0];
  always_comb begin
    tbl_wdata = tbl_rdata;
    if (state == ST_SLEEP) begin
      tbl_wdata.id   = itm.thread_id;
      tbl_wdata.wake = wake_sat;
    end
  end

  stq_table #(.SLOTS(SLOTS)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (state == ST_SCAN && issue),
    .raddr (rd_cnt[IW-1:0]),
    .rdata (tbl_rdata)
  );

  assign counting = (policy == POL_RR) || (policy == POL_ML && itm.current_in_rr);
  assign tid_ok   = (32'(itm.thread_id) < THREADS);
  assign q_inc    = (q_rd == 8'hFF) ? q_rd : q_rd + 8'd1;
  assign q_we     = (state == ST_DECIDE) && counting && tid_ok;

  stq_quanta #(.THREADS(THREADS)) u_quanta (
    .clk   (clk),
    .rst   (rst),
    .re    (accept),
    .raddr (QW'(req.thread_id)),
    .rdata (q_rd),
    .we    (q_we),
    .waddr (QW'(itm.thread_id)),
    .wdata (q_inc)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      itm <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= POLICY_RESET;
      max_quanta <= MAX_QUANTA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_POLICY:     policy     <= cfg_data[2:0];
        CFG_MAX_QUANTA: max_quanta <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rd_cnt    <= '0;
      kept      <= '0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rd_cnt  <= '0;
            kept    <= '0;
            rd_pend <= 1'b0;
            if (req.action == ACT_TICK) begin
              state <= ST_SCAN;
            end else if (full) begin
              res_valid <= 1'b1;
              res       <= '{wake_valid: 1'b0, wake_thread: 6'd0, yield_now: 1'b0,
                             leave_rr: 1'b0, queue_full: 1'b1, last: 1'b1};
            end else begin
              state <= ST_SLEEP;
            end
          end
        end
        ST_SLEEP: begin
          count <= count + CW'(1);
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          // read of entry rd_cnt overlaps compare of the entry read last cycle
          if (issue) begin
            rd_cnt <= rd_cnt + CW'(1);
          end else begin
            state <= ST_DECIDE;
          end
          rd_pend <= issue;
          if (rd_pend) begin
            if (expired) begin
              res_valid <= 1'b1;
              res       <= '{wake_valid: 1'b1, wake_thread: tbl_rdata.id, yield_now: 1'b0,
                             leave_rr: 1'b0, queue_full: 1'b0, last: 1'b0};
            end else begin
              kept <= kept + CW'(1);
            end
          end
        end
        ST_DECIDE: begin
          count     <= kept;
          state     <= ST_IDLE;
          res_valid <= 1'b1;
          res       <= '{wake_valid: 1'b0, wake_thread: 6'd0,
                         yield_now: counting || (policy == POL_PRIO),
                         leave_rr: counting && tid_ok && (q_inc >= max_quanta),
                         queue_full: 1'b0, last: 1'b1};
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SLOTS))
    else $error("sleeper count past table size");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> kept <= rd_cnt)
    else $error("compaction index ahead of scan");

  a_decide_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECIDE |=> res_valid && res.last && !res.wake_valid)
    else $error("tick did not end with a decision result");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.queue_full |-> res.last && !res.wake_valid && $past(full))
    else $error("queue_full result without a full table");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the sleep timer queue with tick-driven preemption.
module testbench;
  import stq_pkg::*;

  localparam int SLOTS   = 16;
  localparam int THREADS = 64;
  localparam int LIMIT   = 400000;

  localparam logic [2:0] POL_HRRN     = 3'd3;
  localparam logic [2:0] POL_LOTTERY  = 3'd4;
  localparam logic [2:0] POL_TOP_CODE = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  req_t       req = '0;
  logic       res_valid;
  res_t       res;
  logic       cfg_we = 1'b0;
  logic       cfg_idx = CFG_POLICY;
  logic [7:0] cfg_data = '0;

  sleep_timer_queue_with_preempt #(.SLOTS(SLOTS), .THREADS(THREADS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .res_valid(res_valid), .res(res),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow of the block's state and registers
  logic [5:0]  slot_id   [SLOTS];
  logic [31:0] slot_wake [SLOTS];
  int          n_sleepers = 0;
  logic [7:0]  quanta [THREADS] = '{default: 8'd0};
  logic [2:0]  cur_policy = POLICY_RESET;
  logic [7:0]  cur_max_quanta = MAX_QUANTA_RESET;

  res_t        owed_results [$];
  int          errors = 0;
  int          cycle_count = 0;
  bit          no_gaps = 1'b0;
  logic [31:0] tb_now = '0;

  int n_sleeps = 0, n_drops = 0, n_ticks = 0, n_wakes = 0, n_leave = 0;

  task automatic compute_sched_outcome(req_t r);
    res_t        o;
    logic [32:0] sum;
    int          kept;
    o = '0;
    if (r.action == ACT_SLEEP) begin
      if (n_sleepers >= SLOTS) begin
        o.queue_full = 1'b1;
        o.last = 1'b1;
        owed_results.push_back(o);
        n_drops++;
      end else begin
        sum = {1'b0, r.now} + {1'b0, r.delay};
        slot_id[n_sleepers] = r.thread_id;
        slot_wake[n_sleepers] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        n_sleepers++;
        n_sleeps++;
      end
    end else begin
      kept = 0;
      for (int i = 0; i < n_sleepers; i++) begin
        if (slot_wake[i] <= r.now) begin
          o = '0;
          o.wake_valid = 1'b1;
          o.wake_thread = slot_id[i];
          owed_results.push_back(o);
          n_wakes++;
        end else begin
          slot_id[kept] = slot_id[i];
          slot_wake[kept] = slot_wake[i];
          kept++;
        end
      end
      n_sleepers = kept;
      o = '0;
      o.last = 1'b1;
      if (cur_policy == POL_RR || (cur_policy == POL_ML && r.current_in_rr)) begin
        if (quanta[r.thread_id] != 8'hFF) quanta[r.thread_id]++;
        o.leave_rr = (quanta[r.thread_id] >= cur_max_quanta);
        o.yield_now = 1'b1;
      end else if (cur_policy == POL_PRIO) begin
        o.yield_now = 1'b1;
      end
      if (o.leave_rr) n_leave++;
      owed_results.push_back(o);
      n_ticks++;
    end
  endtask

  // Entered right after a rising edge; returns at the edge that took the request.
  task automatic issue_request(req_t r);
    while (!no_gaps && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    compute_sched_outcome(r);
  endtask

  function automatic req_t make_req(logic act, logic [5:0] tid, logic [31:0] dly,
                                    logic [31:0] at, logic in_rr);
    req_t r;
    r.action = act;
    r.thread_id = tid;
    r.delay = dly;
    r.now = at;
    r.current_in_rr = in_rr;
    return r;
  endfunction

  task automatic wait_all_results();
    start <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // A sleep leaves no result behind, so give the block time to go idle.
  task automatic quiesce();
    wait_all_results();
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLICY) cur_policy = val[2:0];
    else cur_max_quanta = val;
    @(posedge clk);
  endtask

  task automatic set_config(logic [2:0] pol, logic [7:0] maxq);
    quiesce();
    write_reg(CFG_POLICY, {5'b0, pol});
    write_reg(CFG_MAX_QUANTA, maxq);
  endtask

  // Fill every slot with edge values, overflow once, then drain in two scans.
  task automatic test_full_table();
    issue_request(make_req(ACT_SLEEP, 6'd3, 32'd0, 32'd100, 1'b0));
    issue_request(make_req(ACT_SLEEP, 6'd63, 32'd5, 32'd100, 1'b1));
    issue_request(make_req(ACT_SLEEP, 6'd0, 32'd0, 32'd0, 1'b0));
    issue_request(make_req(ACT_SLEEP, 6'd42, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b1));
    issue_request(make_req(ACT_SLEEP, 6'd3, 32'd60, 32'd50, 1'b0));
    issue_request(make_req(ACT_SLEEP, 6'd21, 32'h8000_0000, 32'h8000_0000, 1'b0));
    for (int i = 0; i < SLOTS - 6; i++)
      issue_request(make_req(ACT_SLEEP, 6'(i + 10), 32'(i * 2), 32'd95, 1'($urandom)));
    issue_request(make_req(ACT_SLEEP, 6'd1, 32'd1, 32'd1, 1'b1));
    // Partial scan keeps later entries in order; reset policy and max_quanta apply.
    issue_request(make_req(ACT_TICK, 6'd7, 32'd0, 32'd104, 1'b0));
    issue_request(make_req(ACT_TICK, 6'd7, 32'hFFFF_FFFF, 32'd0, 1'b1));
    issue_request(make_req(ACT_TICK, 6'd7, 32'd0, 32'hFFFF_FFFF, 1'b0));
    issue_request(make_req(ACT_TICK, 6'd7, 32'd0, 32'd5, 1'b1));
  endtask

  task automatic test_policies();
    for (int p = 0; p <= POL_TOP_CODE; p++) begin
      set_config(p[2:0], (p == POL_RR) ? 8'd0 : (p == POL_ML) ? 8'd255 : 8'd1);
      issue_request(make_req(ACT_TICK, 6'd9, 32'($urandom), 32'd7, 1'b0));
      if (p == POL_ML || p == POL_HRRN || p == POL_LOTTERY)
        issue_request(make_req(ACT_TICK, 6'd9, 32'($urandom), 32'd8, 1'b1));
    end
  endtask

  // One thread ticks past its limit so leave_rr turns on mid-run.
  task automatic test_quanta_limit();
    set_config(POL_RR, 8'd32);
    for (int i = 0; i < 40; i++)
      issue_request(make_req(ACT_TICK, 6'd62, 32'($urandom), 32'($urandom), 1'($urandom)));
  endtask

  task automatic send_random_item();
    req_t r;
    int   pick;
    r.action = ($urandom_range(0, 99) < 55) ? ACT_SLEEP : ACT_TICK;
    r.thread_id = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 7));
    r.current_in_rr = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      r.now = $urandom;
      r.delay = $urandom;
    end else begin
      if (r.action == ACT_TICK) tb_now = tb_now + 32'($urandom_range(0, 12));
      else if (pick == 1) tb_now = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
      r.now = tb_now;
      case (pick)
        2:       r.delay = '0;
        3:       r.delay = $urandom;
        4:       r.delay = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
        default: r.delay = 32'($urandom_range(1, 30));
      endcase
    end
    issue_request(r);
  endtask

  task automatic test_random_traffic(int per_phase);
    logic [2:0] pol;
    logic [7:0] maxq;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin pol = POL_RR; maxq = 8'd255; end
        1:       begin pol = POL_ML; maxq = 8'd1; end
        2:       begin pol = 3'($urandom_range(0, 7)); maxq = 8'($urandom_range(0, 255)); end
        default: begin pol = 3'($urandom_range(0, 4)); maxq = 8'($urandom_range(2, 10)); end
      endcase
      set_config(pol, maxq);
      no_gaps = (ph == 1);
      for (int i = 0; i < per_phase; i++) begin
        if (i == per_phase / 2) wait_all_results();
        send_random_item();
      end
      no_gaps = 1'b0;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && res_valid === 1'b1) begin
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with none pending: got %p", $time, res);
      end else begin
        want = owed_results.pop_front();
        if (res !== want) begin
          errors++;
          $display("%0t: result mismatch: expected %p, got %p", $time, want, res);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_full_table();
    test_policies();
    test_quanta_limit();
    test_random_traffic(60);
    quiesce();
    $display("Covered %0d sleeps, %0d dropped on full table, %0d ticks, %0d wakeups,",
             n_sleeps, n_drops, n_ticks, n_wakes);
    $display("%0d leave-rr decisions across all policy codes and quanta limits.", n_leave);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/stq_pkg.sv
rtl/stq_alu.sv
rtl/stq_table.sv
rtl/stq_quanta.sv
rtl/sleep_timer_queue_with_preempt.sv
tb/testbench.sv
